@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the motion report builder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MMRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MMRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mmrb_pkg.sv @@
// ----------------------------------------------------------------------------
// mmrb_pkg
// Types and constants shared by the motion report builder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mmrb_pkg;

  // Input opcodes; code 3 is unused and is dropped by the front end.
  typedef enum logic [1:0] {
    OP_MOVE   = 2'd0,
    OP_BUTTON = 2'd1,
    OP_POLL   = 2'd2
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MIN_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_MAX_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_ACCELERATE = 2'd2;
  localparam logic [1:0] CFG_DOWNSCALE  = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int LIM_W      = 11;
  localparam int MAXL_W     = 10;
  localparam int DELTA_W    = 16;
  localparam int MOVE_W     = 12;
  localparam int WHEEL_W    = 4;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 72;

  localparam int QDEPTH = 2;

  localparam logic signed [LIM_W-1:0] MIN_LIMIT_RST = -11'sd255;
  localparam logic [MAXL_W-1:0]       MAX_LIMIT_RST = 10'd255;

  localparam logic signed [WHEEL_W-1:0] WHEEL_MIN = -4'sd8;
  localparam logic signed [WHEEL_W-1:0] WHEEL_MAX = 4'sd7;

  localparam logic [7:0] PKT_SYNC   = 8'b0000_1000;
  localparam logic [7:0] PKT_Y_NEG  = 8'b0010_0000;
  localparam logic [7:0] PKT_X_NEG  = 8'b0001_0000;
  localparam logic [7:0] PKT_BTN_M  = 8'h07;
  localparam logic [7:0] BYTE_MASK  = 8'hFF;

  // Acceleration curve for magnitudes below six, indexed by value + 5.
  localparam logic signed [4:0] ACCEL_LUT [11] = '{
    -5'sd9, -5'sd6, -5'sd3, -5'sd1, -5'sd1, 5'sd0,
    5'sd1, 5'sd1, 5'sd3, 5'sd6, 5'sd9
  };

  typedef struct packed {
    logic [LIM_W-1:0]  min_limit;
    logic [MAXL_W-1:0] max_limit;
    logic              accelerate;
    logic [1:0]        downscale;
  } cfg_t;

  // One classified command waiting in the queue.
  typedef struct packed {
    op_t              op;
    logic [DELTA_W-1:0] delta_x;
    logic [DELTA_W-1:0] delta_y;
    logic [DELTA_W-1:0] delta_z;
    logic [7:0]       btn_mask;
    logic             btn_pressed;
  } cmd_t;

  typedef struct packed {
    logic               has_update;
    logic [MOVE_W-1:0]  move_x;
    logic [MOVE_W-1:0]  move_y;
    logic [WHEEL_W-1:0] move_z;
    logic [7:0]         button_mask;
    logic [7:0]         packet_byte1;
    logic [7:0]         packet_byte2;
    logic [7:0]         packet_byte3;
    logic [7:0]         packet_byte4;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/mmrb_front.sv @@
// ----------------------------------------------------------------------------
// mmrb_front
// Accepts input requests, classifies the opcode and decodes the button bit.
// ----------------------------------------------------------------------------
`default_nettype none

module mmrb_front (
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [mmrb_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic [mmrb_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  wire logic                              q_ready,
  output logic                                   q_push,
  output mmrb_pkg::cmd_t                         q_cmd
);

  logic known_op;

  assign in_tready = q_ready;

  // Unused opcodes are accepted and dropped here.
  always_comb begin
    unique case (mmrb_pkg::op_t'(in_tuser))
      mmrb_pkg::OP_MOVE, mmrb_pkg::OP_BUTTON, mmrb_pkg::OP_POLL: known_op = 1'b1;
      default: known_op = 1'b0;
    endcase
  end

  assign q_push = in_tvalid && q_ready && known_op;

  always_comb begin
    q_cmd.op          = mmrb_pkg::op_t'(in_tuser);
    q_cmd.delta_x     = in_tdata[15:0];
    q_cmd.delta_y     = in_tdata[31:16];
    q_cmd.delta_z     = in_tdata[47:32];
    q_cmd.btn_mask    = 8'd1 << in_tdata[50:48];
    q_cmd.btn_pressed = in_tdata[51];
  end

endmodule

`default_nettype wire

@@ rtl/core/mmrb_queue.sv @@
// ----------------------------------------------------------------------------
// mmrb_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mmrb_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  mmrb_pkg::cmd_t      push_cmd,
  output logic                not_full,
  input  wire logic           pop,
  output logic                not_empty,
  output mmrb_pkg::cmd_t      head_cmd
);

  `include "assert_macros.svh"

  localparam int PTR_W = (mmrb_pkg::QDEPTH > 1) ? $clog2(mmrb_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(mmrb_pkg::QDEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(mmrb_pkg::QDEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(mmrb_pkg::QDEPTH - 1);

  mmrb_pkg::cmd_t   slot_r [mmrb_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_full  = (count_r != DEPTH_C);
  assign not_empty = (count_r != '0);
  assign head_cmd  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  `MMRB_ASSERT_IMP(a_q_no_overflow, clk, rst_n, push && !pop, count_r < DEPTH_C, "queue overflow")
  `MMRB_ASSERT_IMP(a_q_no_underflow, clk, rst_n, pop, count_r != '0, "queue underflow")
  `MMRB_ASSERT_IMP(a_q_count_range, clk, rst_n, 1'b1, count_r <= DEPTH_C, "queue count out of range")

endmodule

`default_nettype wire

@@ rtl/core/mmrb_back.sv @@
// ----------------------------------------------------------------------------
// mmrb_back
// Holds the motion state, retires one queued command per cycle unless a poll
// waits for the output register to free up, and builds the report into it.
// ----------------------------------------------------------------------------
`default_nettype none

module mmrb_back #(
  parameter int ACC_WIDTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  mmrb_pkg::cfg_t      cfg,
  input  wire logic           cmd_valid,
  input  mmrb_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                res_valid,
  input  wire logic           res_ready,
  output mmrb_pkg::result_t   res
);

  `include "assert_macros.svh"

  localparam int CMP_W = 33;
  localparam int LW    = mmrb_pkg::LIM_W;
  localparam int MW    = mmrb_pkg::MOVE_W;

  typedef struct packed {
    logic [LW-1:0] v;
    logic          clamped;
  } take_t;

  function automatic take_t take_axis(input logic signed [CMP_W-1:0] val,
                                      input logic signed [CMP_W-1:0] lo,
                                      input logic signed [CMP_W-1:0] hi);
    take_t t;
    t.clamped = 1'b1;
    if (val < lo) begin
      t.v = lo[LW-1:0];
    end else if (val > hi) begin
      t.v = hi[LW-1:0];
    end else begin
      t.v       = val[LW-1:0];
      t.clamped = 1'b0;
    end
    return t;
  endfunction

  function automatic logic [MW-1:0] accel(input logic signed [LW-1:0] v);
    logic [3:0] idx;
    idx = 4'(v + 11'sd5);
    if (v > -11'sd6 && v < 11'sd6) begin
      return MW'(mmrb_pkg::ACCEL_LUT[idx]);
    end
    return {v, 1'b0};
  endfunction

  logic [ACC_WIDTH-1:0] acc_x_r, acc_x_nxt;
  logic [ACC_WIDTH-1:0] acc_y_r, acc_y_nxt;
  logic [ACC_WIDTH-1:0] acc_z_r, acc_z_nxt;
  logic [7:0]           buttons_r, buttons_nxt;
  logic                 pending_r, pending_nxt;
  logic                 out_valid_r, out_valid_nxt;
  mmrb_pkg::result_t    out_r, out_nxt;

  logic                        slot_free;
  logic                        poll_go;
  logic signed [ACC_WIDTH-1:0] x_shift, y_shift;
  logic signed [CMP_W-1:0]     lo_w, hi_w;
  take_t                       tx, ty, tz;
  logic [mmrb_pkg::WHEEL_W-1:0] vz;
  logic [MW-1:0]               x12, y12, ny12;
  logic [7:0]                  z8;
  mmrb_pkg::result_t           report;

  assign slot_free = !out_valid_r || res_ready;
  assign cmd_pop   = cmd_valid && ((cmd.op != mmrb_pkg::OP_POLL) || slot_free);
  assign poll_go   = cmd_pop && (cmd.op == mmrb_pkg::OP_POLL);

  // Report datapath: shift, clamp, acceleration and packet bytes.
  always_comb begin
    x_shift = $signed(acc_x_r) >>> cfg.downscale;
    y_shift = $signed(acc_y_r) >>> cfg.downscale;
    lo_w    = CMP_W'($signed(cfg.min_limit));
    hi_w    = CMP_W'($signed({1'b0, cfg.max_limit}));
    tx      = take_axis(CMP_W'(x_shift), lo_w, hi_w);
    ty      = take_axis(CMP_W'(y_shift), lo_w, hi_w);
    tz      = take_axis(CMP_W'($signed(acc_z_r)), CMP_W'(mmrb_pkg::WHEEL_MIN),
                        CMP_W'(mmrb_pkg::WHEEL_MAX));
    vz      = tz.v[mmrb_pkg::WHEEL_W-1:0];
    x12     = cfg.accelerate ? accel($signed(tx.v)) : MW'($signed(tx.v));
    y12     = cfg.accelerate ? accel($signed(ty.v)) : MW'($signed(ty.v));
    ny12    = MW'(0) - y12;
    z8      = 8'(0) - 8'($signed(vz));

    report.has_update   = 1'b1;
    report.move_x       = x12;
    report.move_y       = y12;
    report.move_z       = vz;
    report.button_mask  = buttons_r;
    report.packet_byte1 = mmrb_pkg::PKT_SYNC
                        | (($signed(y12) > 12'sd0) ? mmrb_pkg::PKT_Y_NEG : 8'h00)
                        | (x12[MW-1] ? mmrb_pkg::PKT_X_NEG : 8'h00)
                        | (buttons_r & mmrb_pkg::PKT_BTN_M);
    report.packet_byte2 = x12[7:0];
    report.packet_byte3 = ny12[7:0];
    report.packet_byte4 = z8 & mmrb_pkg::BYTE_MASK;
  end

  always_comb begin
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    acc_z_nxt     = acc_z_r;
    buttons_nxt   = buttons_r;
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r && !res_ready;
    out_nxt       = out_r;
    if (cmd_pop) begin
      case (cmd.op)
        mmrb_pkg::OP_MOVE: begin
          acc_x_nxt   = acc_x_r + ACC_WIDTH'($signed(cmd.delta_x));
          acc_y_nxt   = acc_y_r + ACC_WIDTH'($signed(cmd.delta_y));
          acc_z_nxt   = acc_z_r + ACC_WIDTH'($signed(cmd.delta_z));
          pending_nxt = 1'b1;
        end
        mmrb_pkg::OP_BUTTON: begin
          buttons_nxt = cmd.btn_pressed ? (buttons_r | cmd.btn_mask)
                                        : (buttons_r & ~cmd.btn_mask);
          pending_nxt = 1'b1;
        end
        mmrb_pkg::OP_POLL: begin
          out_valid_nxt = 1'b1;
          if (pending_r) begin
            acc_x_nxt   = acc_x_r - (ACC_WIDTH'($signed(tx.v)) << cfg.downscale);
            acc_y_nxt   = acc_y_r - (ACC_WIDTH'($signed(ty.v)) << cfg.downscale);
            acc_z_nxt   = acc_z_r - ACC_WIDTH'($signed(vz));
            pending_nxt = tx.clamped || ty.clamped || tz.clamped;
            out_nxt     = report;
          end else begin
            out_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_z_r     <= '0;
      buttons_r   <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_x_r     <= acc_x_nxt;
      acc_y_r     <= acc_y_nxt;
      acc_z_r     <= acc_z_nxt;
      buttons_r   <= buttons_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

  `MMRB_ASSERT_IMP(a_empty_report_zero, clk, rst_n, out_valid_r && !out_r.has_update, out_r.move_x == '0 && out_r.packet_byte1 == '0, "empty report carries data")
  `MMRB_ASSERT_IMP(a_pending_falls_on_poll, clk, rst_n, $fell(pending_r), !$past(rst_n) || $past(poll_go), "pending cleared without a poll")
  `MMRB_ASSERT_NXT(a_poll_loads_result, clk, rst_n, poll_go, out_valid_r, "poll left no result")

endmodule

`default_nettype wire

@@ rtl/core/mouse_motion_report_builder.sv @@
// ----------------------------------------------------------------------------
// mouse_motion_report_builder
// Accumulates mouse motion and button changes and answers polls with a
// clamped, optionally accelerated four-byte movement packet.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   in_       slave      in_tvalid/in_tready  in_tuser opcode, in_tdata deltas/button
//   out_      master     out_tvalid/out_tready out_tuser has_update, out_tdata report
//   cfg_      write      cfg_we               cfg_addr index, cfg_wdata value
//
// One request is taken every cycle while the queue has room. The front end
// decodes a request into a two-entry queue in the accepting cycle, and the
// back end retires one queued command per cycle unless a poll must wait; a
// poll result is loaded from the queue head into the output register, where
// it waits until the sink takes it. A poll only waits when the output
// register holds a result that the sink has not yet taken; move and button
// requests never wait on the output side. Once the queue holds such a poll
// and one command behind it, in_tready drops. The synchronous reset clears
// the queue, the accumulators, the button bits and the pending flag, and
// loads the default limits (-255 and 255), no acceleration and no downscale.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_motion_report_builder #(
  parameter int ACC_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] delta_x, [31:16] delta_y, [47:32] delta_z, [50:48] button_index,
  // [51] button_pressed, [55:52] zero.
  input  wire logic [mmrb_pkg::IN_TDATA_W-1:0] in_tdata,
  // [1:0] opcode.
  input  wire logic [mmrb_pkg::IN_TUSER_W-1:0] in_tuser,
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [11:0] move_x, [23:12] move_y, [27:24] move_z, [35:28] button_mask,
  // [43:36] packet_byte1, [51:44] packet_byte2, [59:52] packet_byte3,
  // [67:60] packet_byte4, [71:68] zero.
  output logic [mmrb_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] has_update.
  output logic             out_tuser,
  // Configuration port.
  input  wire logic        cfg_we,
  input  wire logic [mmrb_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [mmrb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mmrb_pkg::cfg_t    cfg_r, cfg_nxt;
  mmrb_pkg::cmd_t    front_cmd, head_cmd;
  mmrb_pkg::result_t res;
  logic              q_push, q_not_full, q_not_empty, q_pop;

  // Configuration registers. Writes must only happen while the block is idle, so
  // the back end sees a stable setting for every command; the block does not check.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        mmrb_pkg::CFG_MIN_LIMIT:  cfg_nxt.min_limit  = cfg_wdata[mmrb_pkg::LIM_W-1:0];
        mmrb_pkg::CFG_MAX_LIMIT:  cfg_nxt.max_limit  = cfg_wdata[mmrb_pkg::MAXL_W-1:0];
        mmrb_pkg::CFG_ACCELERATE: cfg_nxt.accelerate = cfg_wdata[0];
        mmrb_pkg::CFG_DOWNSCALE:  cfg_nxt.downscale  = cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_limit  <= mmrb_pkg::MIN_LIMIT_RST;
      cfg_r.max_limit  <= mmrb_pkg::MAX_LIMIT_RST;
      cfg_r.accelerate <= 1'b0;
      cfg_r.downscale  <= 2'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: takes a request and classifies it.
  mmrb_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_ready   (q_not_full),
    .q_push    (q_push),
    .q_cmd     (front_cmd)
  );

  // Queue between the two halves so each can stall on its own.
  mmrb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (front_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // Back end: motion state, report datapath and output register.
  mmrb_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (q_not_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tuser = res.has_update;
  assign out_tdata = {4'b0000, res.packet_byte4, res.packet_byte3, res.packet_byte2,
                      res.packet_byte1, res.button_mask, res.move_z, res.move_y,
                      res.move_x};

endmodule

`default_nettype wire

@@ sim/mouse_motion_report_builder_tb.sv @@
// ----------------------------------------------------------------------------
// mouse_motion_report_builder_tb
// Self-checking bench for the mouse motion report builder: a directed pass
// over idle polls, exact and exceeded limits, inverted limits, button bits and
// the acceleration curve, then randomized motion, button and poll traffic
// under several limit settings and back-pressure mixes. Every poll report is
// predicted at acceptance and compared field by field when it leaves the block.
// ----------------------------------------------------------------------------
module mouse_motion_report_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode 3 has no meaning; the block must swallow it without a report.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Enough edges for the two-entry command queue and the output register to
  // empty out after the last report has been taken.
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 200;

  // Packet byte 1 layout.
  localparam logic [7:0] SYNC_BIT   = 8'h08;
  localparam logic [7:0] Y_SIGN_BIT = 8'h20;
  localparam logic [7:0] X_SIGN_BIT = 8'h10;
  localparam logic [7:0] LOW_BTNS   = 8'h07;

  // Acceleration curve for magnitudes below six, indexed by value + 5.
  localparam int ACCEL_CURVE [11] = '{-9, -6, -3, -1, -1, 0, 1, 1, 3, 6, 9};

  typedef struct packed {
    logic        has_update;
    logic [11:0] move_x;
    logic [11:0] move_y;
    logic [3:0]  move_z;
    logic [7:0]  button_mask;
    logic [7:0]  packet_byte1;
    logic [7:0]  packet_byte2;
    logic [7:0]  packet_byte3;
    logic [7:0]  packet_byte4;
  } report_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // delta_x, delta_y, delta_z, button_index, button_pressed
  logic [1:0]  in_tuser;   // opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // move_x, move_y, move_z, button_mask, packet bytes 1-4
  logic        out_tuser;  // has_update
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [10:0] cfg_wdata;

  mouse_motion_report_builder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block's accumulated motion, buttons and pending flag.
  logic [15:0]        motion_x;
  logic [15:0]        motion_y;
  logic [15:0]        motion_z;
  logic [7:0]         held_buttons;
  bit                 report_owed;
  // Shadow of the configuration registers.
  logic signed [10:0] floor_limit;
  logic [9:0]         ceil_limit;
  bit                 accel_on;
  logic [1:0]         shift_amt;

  // Reports predicted at acceptance of each poll, oldest first.
  report_t expected_reports [$];

  int mismatches;
  int cycle_count;
  int gap_pct;    // chance in a hundred that the sender idles in a cycle
  int stall_pct;  // chance in a hundred that the sink holds off in a cycle

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost report ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mouse_motion_report_builder: mismatch");
      $finish;
    end
  end

  // The sink decides once per cycle, at the falling edge, whether it takes a
  // report. With stall_pct at zero it never holds off.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Takes one reported amount out of an accumulator. The accumulator is
  // shifted arithmetically, clamped (the lower bound is tested first, which
  // decides the case where the limits are inverted), and the clamped amount,
  // shifted back up, is subtracted. Landing exactly on a limit is not a clamp.
  function automatic longint take_motion(inout logic [15:0] acc, input longint lo,
                                         input longint hi, input int unsigned sh,
                                         inout bit clipped);
    longint v;
    v = longint'($signed(acc)) >>> sh;
    if (v < lo) begin
      v = lo;
      clipped = 1'b1;
    end else if (v > hi) begin
      v = hi;
      clipped = 1'b1;
    end
    acc = acc - 16'(v <<< sh);
    return v;
  endfunction

  function automatic longint boost(input longint v);
    if (v > -6 && v < 6) return ACCEL_CURVE[int'(v + 5)];
    return 2 * v;
  endfunction

  // Applies one accepted request to the shadow state. A poll always yields a
  // report: all zero when nothing is owed, otherwise the packet.
  function automatic void apply_request(input logic [1:0] opcode, input logic [15:0] dx,
                                        input logic [15:0] dy, input logic [15:0] dz,
                                        input logic [2:0] idx, input logic pressed);
    longint  x, y, z, yn, zn;
    bit      clipped;
    report_t r;
    r = '0;
    case (opcode)
      mmrb_pkg::OP_MOVE: begin
        motion_x    = motion_x + dx;
        motion_y    = motion_y + dy;
        motion_z    = motion_z + dz;
        report_owed = 1'b1;
      end
      mmrb_pkg::OP_BUTTON: begin
        if (pressed) held_buttons = held_buttons | (8'd1 << idx);
        else held_buttons = held_buttons & ~(8'd1 << idx);
        report_owed = 1'b1;
      end
      mmrb_pkg::OP_POLL: begin
        if (report_owed) begin
          clipped = 1'b0;
          x = take_motion(motion_x, longint'(floor_limit), longint'(ceil_limit),
                          shift_amt, clipped);
          y = take_motion(motion_y, longint'(floor_limit), longint'(ceil_limit),
                          shift_amt, clipped);
          z = take_motion(motion_z, -8, 7, 0, clipped);
          // Anything left behind by a clamp is reported on a later poll.
          report_owed = clipped;
          if (accel_on) begin
            x = boost(x);
            y = boost(y);
          end
          yn = -y;
          zn = -z;
          r.has_update   = 1'b1;
          r.move_x       = x[11:0];
          r.move_y       = y[11:0];
          r.move_z       = z[3:0];
          r.button_mask  = held_buttons;
          r.packet_byte1 = SYNC_BIT | ((yn < 0) ? Y_SIGN_BIT : 8'h00) |
                           ((x < 0) ? X_SIGN_BIT : 8'h00) | (held_buttons & LOW_BTNS);
          r.packet_byte2 = x[7:0];
          r.packet_byte3 = yn[7:0];
          r.packet_byte4 = zn[7:0];
        end
        expected_reports.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Every report taken by the sink is matched against the oldest prediction.
  always @(posedge clk) begin : check_reports
    report_t got;
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.has_update   = out_tuser;
      got.move_x       = out_tdata[11:0];
      got.move_y       = out_tdata[23:12];
      got.move_z       = out_tdata[27:24];
      got.button_mask  = out_tdata[35:28];
      got.packet_byte1 = out_tdata[43:36];
      got.packet_byte2 = out_tdata[51:44];
      got.packet_byte3 = out_tdata[59:52];
      got.packet_byte4 = out_tdata[67:60];
      if (expected_reports.size() == 0) begin
        $error("report arrived with no poll outstanding");
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        compare_field("has_update", want.has_update, got.has_update);
        compare_field("move_x", want.move_x, got.move_x);
        compare_field("move_y", want.move_y, got.move_y);
        compare_field("move_z", want.move_z, got.move_z);
        compare_field("button_mask", want.button_mask, got.button_mask);
        compare_field("packet_byte1", want.packet_byte1, got.packet_byte1);
        compare_field("packet_byte2", want.packet_byte2, got.packet_byte2);
        compare_field("packet_byte3", want.packet_byte3, got.packet_byte3);
        compare_field("packet_byte4", want.packet_byte4, got.packet_byte4);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Presents one request from a falling edge, after idling for a random number
  // of cycles, and holds it until the block takes it. The prediction is made at
  // the accepting edge. The caller's next step always starts at a falling edge,
  // where it either replaces the request or drops valid, so nothing is taken
  // twice.
  task automatic push_request(input logic [1:0] opcode, input logic [15:0] dx,
                              input logic [15:0] dy, input logic [15:0] dz,
                              input logic [2:0] idx, input logic pressed);
    @(negedge clk);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = opcode;
    in_tdata  = {4'b0000, pressed, idx, dz, dy, dx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_request(opcode, dx, dy, dz, idx, pressed);
  endtask

  // Unused fields of a request carry random bits; the block must ignore them.
  task automatic send_move(input int dx, input int dy, input int dz);
    push_request(mmrb_pkg::OP_MOVE, 16'(dx), 16'(dy), 16'(dz), 3'($urandom),
                 1'($urandom));
  endtask

  task automatic send_button(input int idx, input bit pressed);
    push_request(mmrb_pkg::OP_BUTTON, 16'($urandom), 16'($urandom), 16'($urandom),
                 3'(idx), pressed);
  endtask

  task automatic send_poll();
    push_request(mmrb_pkg::OP_POLL, 16'($urandom), 16'($urandom), 16'($urandom),
                 3'($urandom), 1'($urandom));
  endtask

  // Stops sending and waits until every predicted report has come out and the
  // queue behind it has had time to empty. Configuration is only written after
  // this, since moves and button changes still in flight give no report.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Called at a falling edge; leaves the port idle at the next falling edge.
  task automatic write_register(input logic [1:0] index, input logic [10:0] value);
    cfg_we    = 1'b1;
    cfg_addr  = index;
    cfg_wdata = value;
    case (index)
      mmrb_pkg::CFG_MIN_LIMIT:  floor_limit = value;
      mmrb_pkg::CFG_MAX_LIMIT:  ceil_limit  = value[9:0];
      mmrb_pkg::CFG_ACCELERATE: accel_on    = value[0];
      mmrb_pkg::CFG_DOWNSCALE:  shift_amt   = value[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_settings(input logic [10:0] lo, input logic [9:0] hi,
                                input bit accel, input logic [1:0] sh);
    settle();
    write_register(mmrb_pkg::CFG_MIN_LIMIT, lo);
    write_register(mmrb_pkg::CFG_MAX_LIMIT, {1'b0, hi});
    write_register(mmrb_pkg::CFG_ACCELERATE, {10'd0, accel});
    write_register(mmrb_pkg::CFG_DOWNSCALE, {9'd0, sh});
  endtask

  // Mostly small motion, which is what reaches the limits and the table edges,
  // with some mid-range values and some fully random words.
  function automatic logic [15:0] random_delta(input int span);
    int k;
    int v;
    k = $urandom_range(99);
    if (k < 75) v = int'($urandom_range(2 * span)) - span;
    else if (k < 90) v = int'($urandom_range(5000)) - 2500;
    else v = int'($urandom());
    return v[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A poll with nothing owed reports all zero; opcode 3 must not mark a
  // report as owed.
  task automatic test_idle_poll();
    send_poll();
    push_request(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1);
    send_poll();
  endtask

  // Exact limits are not clamps, so the second poll finds nothing. Extreme
  // deltas then clamp on every axis and keep the report owed across polls,
  // while button changes show up in the mask and in packet byte 1.
  task automatic test_limits_and_buttons();
    send_move(255, -255, 7);
    send_poll();
    send_poll();
    send_move(32767, -32768, -32768);
    send_button(7, 1'b1);
    send_button(0, 1'b1);
    send_button(7, 1'b0);
    send_poll();
    send_poll();
    send_poll();
  endtask

  // With the lower limit above the upper one, x takes the lower limit, y the upper,
  // and the report stays owed. Downscale by four exercises the arithmetic shift.
  task automatic test_inverted_limits();
    apply_settings(11'd100, 10'd50, 1'b0, 2'd2);
    send_move(-32768, 32767, 8);
    send_poll();
    send_poll();
  endtask

  // Table entries near zero, the first doubled magnitude, and a large value.
  task automatic test_acceleration();
    apply_settings(11'(-255), 10'd255, 1'b1, 2'd0);
    send_move(5, -5, -1);
    send_poll();
    send_move(-6, 6, 0);
    send_poll();
    send_move(-300, 300, 0);
    send_poll();
    send_move(0, -1, 0);
    send_poll();
  endtask

  task automatic run_random(input int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        // Noise: ignored opcode with random payload, not counted.
        push_request(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                     3'($urandom), 1'($urandom));
      end else begin
        if (pick < 45) send_move(int'($signed(random_delta(40))),
                                 int'($signed(random_delta(40))),
                                 int'($signed(random_delta(10))));
        else if (pick < 60) send_button($urandom_range(7), 1'($urandom));
        else send_poll();
        sent++;
      end
    end
  endtask

  // Eight phases: each idle mix appears twice, against default, extreme,
  // degenerate and random settings.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_settings(11'(-255), 10'd255, 1'b0, 2'd0);
        1: apply_settings(11'(-1024), 10'd1023, 1'b1, 2'd3);
        2: apply_settings(11'd0, 10'd0, 1'b0, 2'd0);
        3: apply_settings(11'(-1), 10'd1, 1'b1, 2'd1);
        4: apply_settings(11'(-int'($urandom_range(1024))), 10'($urandom_range(1023)),
                          1'($urandom), 2'($urandom));
        5: apply_settings(11'(-1024), 10'd0, 1'b0, 2'd2);
        6: apply_settings(11'd0, 10'd1023, 1'b1, 2'd0);
        default: apply_settings(11'($urandom), 10'($urandom), 1'($urandom), 2'($urandom));
      endcase
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 68; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 68; end
        default: begin gap_pct = 19; stall_pct = 19; end
      endcase
      run_random(RANDOM_ITEMS);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    out_tready   = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    gap_pct      = 0;
    stall_pct    = 0;
    mismatches   = 0;
    cycle_count  = 0;
    motion_x     = '0;
    motion_y     = '0;
    motion_z     = '0;
    held_buttons = '0;
    report_owed  = 1'b0;
    floor_limit  = 11'(-255);
    ceil_limit   = 10'd255;
    accel_on     = 1'b0;
    shift_amt    = 2'd0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_poll();
    test_limits_and_buttons();
    test_inverted_limits();
    test_acceleration();
    test_random_traffic();
    settle();

    if (mismatches == 0) begin
      $display("mouse_motion_report_builder: match");
    end else begin
      $display("mouse_motion_report_builder: mismatch");
    end
    $finish;
  end

endmodule
